>>> rtl/equal_width_bucket_boundary_finder_unit_defines.svh
// ----------------------------------------------------------------------------
// Equal-width bucket boundary finder: assertion macros
// Shared concurrent-assertion shorthands. Each one samples on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EQUAL_WIDTH_BUCKET_BOUNDARY_FINDER_UNIT_DEFINES_SVH
`define EQUAL_WIDTH_BUCKET_BOUNDARY_FINDER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EWBBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EWBBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ewbbf_pkg.sv
// ----------------------------------------------------------------------------
// Equal-width bucket boundary finder package
// Widths, register indexes, sequencer states and divider handshake types.
// ----------------------------------------------------------------------------
package ewbbf_pkg;

    localparam int MAX_BUCKETS   = 64;
    localparam int STAMP_BITS    = 32;
    localparam int POS_BITS      = 32;
    localparam int CUR_BITS      = 7;
    localparam int BUCKET_BITS   = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int S_TDATA_BITS  = 32;
    localparam int M_TDATA_BITS  = 40;
    localparam int DIV_CNT_BITS  = $clog2(STAMP_BITS);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_START   = 2'd0,
        CFG_MAX_START   = 2'd1,
        CFG_NUM_BUCKETS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIDTH_GO,
        ST_WIDTH_WAIT,
        ST_BUCKET_GO,
        ST_BUCKET_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [STAMP_BITS-1:0] dividend;
        logic [STAMP_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [STAMP_BITS-1:0] quotient;
    } div_resp_t;

endpackage

>>> rtl/ewbbf_divider.sv
// ----------------------------------------------------------------------------
// Equal-width bucket boundary finder: shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ewbbf_divider
    import ewbbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_resp_t resp
);

    logic                    run_reg;
    logic                    run_next;
    logic                    done_reg;
    logic                    done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_CNT_BITS-1:0] cnt_next;
    logic [STAMP_BITS-1:0]   rem_reg;
    logic [STAMP_BITS-1:0]   rem_next;
    logic [STAMP_BITS-1:0]   quo_reg;
    logic [STAMP_BITS-1:0]   quo_next;
    logic [STAMP_BITS-1:0]   dvs_reg;
    logic [STAMP_BITS-1:0]   dvs_next;
    logic [STAMP_BITS:0]     trial;
    logic [STAMP_BITS:0]     diff;

    // The partial remainder stays below the divisor, so it fits the stamp width.
    assign trial = {rem_reg, quo_reg[STAMP_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_BITS'(STAMP_BITS - 1);
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
        end
        else if (run_reg)
        begin
            if (!diff[STAMP_BITS])
            begin
                rem_next = diff[STAMP_BITS-1:0];
                quo_next = {quo_reg[STAMP_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[STAMP_BITS-1:0];
                quo_next = {quo_reg[STAMP_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

>>> rtl/equal_width_bucket_boundary_finder_unit.sv
// ----------------------------------------------------------------------------
// Equal-width bucket boundary finder
// Turns a sorted stream of interval starts into per-bucket end positions.
// ----------------------------------------------------------------------------
// Usage: records arrive on the s_ channel in ascending order of start value,
// one beat per record, with s_tlast set on the last record of a relation.
// For every equal-width bucket that a record skips over, one beat leaves on
// the m_ channel carrying the bucket number and the position of that record;
// on the last record every bucket still open is closed with the record count.
// m_tlast marks the final result beat caused by one input beat, and a record
// that closes no bucket produces no beat at all.
// Timing: the block handles one record at a time and drops s_tready while it
// works. One shared restoring divider, one quotient bit per cycle, sets the
// pace: a record whose start lies above min waits for a bucket division
// before its result beats go out, and the input stays closed until the last
// of them sits in the output register. The first record of a relation also
// waits for the bucket width to be divided out first when max exceeds min.
// Reset clears the configuration to min 0, max 0, one bucket, and returns the
// record position and open bucket to zero. When the receiver stalls, the
// pending result beat holds in the output register and the sequencer waits;
// once the last result of a record sits in that register a new record can be
// accepted while it still waits to be taken.
// Configuration (cfg_we, cfg_index, cfg_data) must be written by the user only
// between relations or while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module equal_width_bucket_boundary_finder_unit
    import ewbbf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,   // [31:0] start_value
    input  logic                     s_tlast,   // end_of_relation
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]  m_tdata,   // [5:0] bucket_number, [37:6] boundary_position
    output logic                     m_tlast,   // last_of_run
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Configuration registers.
    logic [STAMP_BITS-1:0] min_start_reg;
    logic [STAMP_BITS-1:0] max_start_reg;
    logic [CUR_BITS-1:0]   num_buckets_reg;

    // Sequencer and relation state.
    state_t                state_reg;
    state_t                state_next;
    logic [CUR_BITS-1:0]   cur_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [STAMP_BITS-1:0] width_reg;
    logic [CUR_BITS-1:0]   bkt_reg;

    // Record held while it is processed.
    logic [STAMP_BITS-1:0] start_reg;
    logic                  last_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [BUCKET_BITS-1:0] m_bucket_reg;
    logic [POS_BITS-1:0]   m_pos_reg;
    logic                  m_last_reg;

    div_req_t              div_req;
    div_resp_t             div_resp;

    logic [CUR_BITS-1:0]   nb;
    logic [CUR_BITS-1:0]   nb_last;
    logic [POS_BITS-1:0]   count;
    logic [CUR_BITS-1:0]   target;
    logic                  emit_pending;
    logic                  slot_free;
    logic                  emit_fire;
    logic                  emit_final;
    logic [POS_BITS-1:0]   emit_pos;
    logic                  span_pos;
    logic                  below_min;
    logic                  need_width;
    logic                  accept;
    logic                  width_done;
    logic                  bucket_done;
    logic [CUR_BITS-1:0]   bkt_calc;

    // A bucket count of zero behaves as one, anything above the maximum as the maximum.
    assign nb = (num_buckets_reg == '0) ? CUR_BITS'(1)
              : (num_buckets_reg > CUR_BITS'(MAX_BUCKETS)) ? CUR_BITS'(MAX_BUCKETS)
              : num_buckets_reg;
    assign nb_last = nb - CUR_BITS'(1);

    // The record count saturates at the top of the position range.
    assign count = (pos_reg == '1) ? pos_reg : pos_reg + POS_BITS'(1);

    // On the last record every remaining bucket closes, otherwise only those skipped.
    assign target       = last_reg ? nb : bkt_reg;
    assign emit_pending = cur_reg < target;
    assign slot_free    = !m_valid_reg || m_tready;
    assign emit_fire    = (state_reg == ST_EMIT) && emit_pending && slot_free;
    assign emit_final   = (cur_reg + CUR_BITS'(1)) == target;
    assign emit_pos     = (cur_reg < bkt_reg) ? pos_reg : count;

    // When max does not exceed min on the first record of a relation, the width is one.
    assign span_pos    = max_start_reg > min_start_reg;
    assign below_min   = start_reg <= min_start_reg;
    assign need_width  = (pos_reg == '0) && span_pos;
    assign accept      = s_tvalid && s_tready;
    assign width_done  = (state_reg == ST_WIDTH_WAIT) && div_resp.done;
    assign bucket_done = (state_reg == ST_BUCKET_WAIT) && div_resp.done;

    // The quotient is one below the bucket; clamp it to the last bucket in use.
    assign bkt_calc = (div_resp.quotient >= STAMP_BITS'(nb_last)) ? nb_last
                    : CUR_BITS'(div_resp.quotient) + CUR_BITS'(1);

    ewbbf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_WIDTH_GO;
                end
            end
            ST_WIDTH_GO:
            begin
                state_next = need_width ? ST_WIDTH_WAIT : ST_BUCKET_GO;
            end
            ST_WIDTH_WAIT:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_BUCKET_GO;
                end
            end
            ST_BUCKET_GO:
            begin
                state_next = below_min ? ST_EMIT : ST_BUCKET_WAIT;
            end
            ST_BUCKET_WAIT:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: the input handshake and the divider request.
    always_comb
    begin
        s_tready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = start_reg - min_start_reg - STAMP_BITS'(1);
        div_req.divisor  = (width_reg == '0) ? STAMP_BITS'(1) : width_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_WIDTH_GO:
            begin
                div_req.start    = need_width;
                div_req.dividend = max_start_reg - min_start_reg - STAMP_BITS'(1);
                div_req.divisor  = STAMP_BITS'(nb);
            end
            ST_BUCKET_GO:
            begin
                div_req.start = !below_min;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_start_reg   <= '0;
            max_start_reg   <= '0;
            num_buckets_reg <= CUR_BITS'(1);
            cur_reg         <= '0;
            pos_reg         <= '0;
            width_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_START:   min_start_reg   <= cfg_data[STAMP_BITS-1:0];
                    CFG_MAX_START:   max_start_reg   <= cfg_data[STAMP_BITS-1:0];
                    CFG_NUM_BUCKETS: num_buckets_reg <= cfg_data[CUR_BITS-1:0];
                    default:         num_buckets_reg <= num_buckets_reg;
                endcase
            end

            // The bucket width is latched on the first record of a relation.
            if ((state_reg == ST_WIDTH_GO) && (pos_reg == '0) && !span_pos)
            begin
                width_reg <= STAMP_BITS'(1);
            end
            else if (width_done)
            begin
                width_reg <= div_resp.quotient + STAMP_BITS'(1);
            end

            if (emit_fire)
            begin
                cur_reg <= cur_reg + CUR_BITS'(1);
            end
            else if ((state_reg == ST_EMIT) && !emit_pending)
            begin
                if (last_reg)
                begin
                    cur_reg <= '0;
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= count;
                end
            end

            if (emit_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= s_tdata[STAMP_BITS-1:0];
            last_reg  <= s_tlast;
        end
        if ((state_reg == ST_BUCKET_GO) && below_min)
        begin
            bkt_reg <= '0;
        end
        else if (bucket_done)
        begin
            bkt_reg <= bkt_calc;
        end
        if (emit_fire)
        begin
            m_bucket_reg <= cur_reg[BUCKET_BITS-1:0];
            m_pos_reg    <= emit_pos;
            m_last_reg   <= emit_final;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({m_pos_reg, m_bucket_reg});
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/ewbbf_checker.sv
// ----------------------------------------------------------------------------
// Equal-width bucket boundary finder: port checker
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`include "equal_width_bucket_boundary_finder_unit_defines.svh"

module ewbbf_checker
    import ewbbf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [S_TDATA_BITS-1:0] s_tdata,
    input logic                    s_tlast,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata,
    input logic                    m_tlast
);

    // A stalled result beat keeps its contents.
    `EWBBF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // A record occupies the sequencer, so no record follows directly.
    `EWBBF_ASSERT_NEXT(a_one_record, s_tvalid && s_tready, !s_tready, "record accepted while busy")

    // More results of the same record are pending after a beat without tlast.
    `EWBBF_ASSERT_NEXT(a_run_busy, m_tvalid && m_tready && !m_tlast, !s_tready, "input opened inside a result run")

    // The padding above the boundary position is always zero.
    `EWBBF_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_BITS-1:BUCKET_BITS+POS_BITS] == '0, "result padding not zero")

endmodule

bind equal_width_bucket_boundary_finder_unit ewbbf_checker u_ewbbf_checker (.*);

>>> tb/ewbbf_boundary_monitor.sv
// ----------------------------------------------------------------------------
// Equal-width bucket boundary finder: boundary monitor
// Watches the record, result and register channels, predicts every bucket
// boundary from its own copy of the registers and state, and checks each
// result beat against the oldest boundary still due.
// ----------------------------------------------------------------------------
module ewbbf_boundary_monitor
    import ewbbf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,   // [31:0] start_value
    input  logic                     s_tlast,   // end_of_relation
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [M_TDATA_BITS-1:0]  m_tdata,   // [5:0] bucket_number, [37:6] boundary_position
    input  logic                     m_tlast,   // last_of_run
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       boundaries_due,
    output int                       mismatch_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BUCKET_BITS-1:0] bucket;
        logic [POS_BITS-1:0]    position;
        logic                   closing;
    } boundary_t;

    boundary_t due_boundaries[$];

    logic [STAMP_BITS-1:0] min_start_q;
    logic [STAMP_BITS-1:0] max_start_q;
    logic [CUR_BITS-1:0]   num_buckets_q;

    logic [CUR_BITS-1:0]   open_bucket;
    logic [POS_BITS-1:0]   next_position;
    logic [STAMP_BITS-1:0] latched_width;

    function automatic int unsigned buckets_in_play();
        int unsigned n;
        n = num_buckets_q;
        if (n == 0)
            n = 1;
        if (n > MAX_BUCKETS)
            n = MAX_BUCKETS;
        return n;
    endfunction

    function automatic logic [STAMP_BITS-1:0] width_from_registers();
        longint unsigned span;
        longint unsigned w;
        if (min_start_q == max_start_q)
            span = 1;
        else if (max_start_q < min_start_q)
            span = 0;
        else
            span = longint'(max_start_q) - longint'(min_start_q);
        w = (span == 0) ? 0 : (span - 1) / buckets_in_play() + 1;
        return (w == 0) ? 1 : w[STAMP_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Closes the buckets that one record skips over, and on the last record
    // of a relation every bucket still open, queueing one boundary for each.
    task automatic advance_buckets(input logic [STAMP_BITS-1:0] start, input logic last);
        int unsigned     nb;
        int unsigned     target;
        longint unsigned q;
        logic [POS_BITS-1:0] count;
        int              queued_before;
        nb = buckets_in_play();
        queued_before = due_boundaries.size();
        if (next_position == 0)
            latched_width = width_from_registers();
        if (latched_width == 0)
            latched_width = 1;
        if (start <= min_start_q)
        begin
            target = 0;
        end
        else
        begin
            q = (longint'(start) - longint'(min_start_q) - 1) / latched_width + 1;
            target = (q >= nb) ? nb - 1 : int'(q);
        end
        while (open_bucket < target && open_bucket < nb)
        begin
            due_boundaries.insert(due_boundaries.size(),
                boundary_t'{open_bucket[BUCKET_BITS-1:0], next_position, 1'b0});
            open_bucket++;
        end
        count = (next_position == '1) ? next_position : next_position + 1;
        if (last)
        begin
            while (open_bucket < nb)
            begin
                due_boundaries.insert(due_boundaries.size(),
                    boundary_t'{open_bucket[BUCKET_BITS-1:0], count, 1'b0});
                open_bucket++;
            end
            open_bucket = 0;
            next_position = 0;
        end
        else
        begin
            next_position = count;
        end
        if (due_boundaries.size() > queued_before)
            due_boundaries[due_boundaries.size()-1].closing = 1'b1;
    endtask

    task automatic check_result();
        boundary_t want;
        if (due_boundaries.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing due (bucket %0d, position %0d)",
                                      m_tdata[5:0], m_tdata[37:6]));
        end
        else
        begin
            want = due_boundaries.pop_front();
            if (m_tdata[5:0] !== want.bucket)
                report_mismatch($sformatf("bucket_number %0d, expected %0d",
                                          m_tdata[5:0], want.bucket));
            if (m_tdata[37:6] !== want.position)
                report_mismatch($sformatf("boundary_position %0d for bucket %0d, expected %0d",
                                          m_tdata[37:6], want.bucket, want.position));
            if (m_tlast !== want.closing)
                report_mismatch($sformatf("last_of_run %b for bucket %0d, expected %b",
                                          m_tlast, want.bucket, want.closing));
        end
    endtask

    // Records are predicted before results are checked, so a result taken on
    // the same edge as a new record still meets the older expectation first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_boundaries.delete();
            min_start_q = '0;
            max_start_q = '0;
            num_buckets_q = 1;
            open_bucket = '0;
            next_position = '0;
            latched_width = '0;
            mismatch_count = 0;
            boundaries_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_MIN_START:   min_start_q = cfg_data;
                    CFG_MAX_START:   max_start_q = cfg_data;
                    CFG_NUM_BUCKETS: num_buckets_q = cfg_data[CUR_BITS-1:0];
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_buckets(s_tdata[STAMP_BITS-1:0], s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            boundaries_due <= due_boundaries.size();
        end
    end

endmodule

>>> tb/tb_equal_width_bucket_boundary_finder_unit.sv
// ----------------------------------------------------------------------------
// Equal-width bucket boundary finder: testbench top
// Drives sorted record streams, register settings and handshake pressure
// into the block; the boundary monitor beside it predicts and checks every
// result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_equal_width_bucket_boundary_finder_unit
    import ewbbf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to wait after the last due boundary before touching registers.
    // A record that closes no bucket gives no sign of being finished; the
    // slowest one is the first of a relation, which waits for two divisions.
    localparam int SETTLE_CYCLES = 100;

    // The longest honest silence is a settle pause followed by a long sender
    // gap, or one slow record whose result waits behind a stalled receiver.
    // This limit is several times that.
    localparam int QUIET_LIMIT = 4000;

    // Roughly this many records in each random register setting.
    localparam int RECORDS_PER_SETTING = 21;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata = '0;   // [31:0] start_value
    logic                     s_tlast = 1'b0; // end_of_relation
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;        // [5:0] bucket_number, [37:6] boundary_position
    logic                     m_tlast;        // last_of_run
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_MIN_START;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int boundaries_due;
    int mismatch_count;

    // Percent of cycles in which the sender holds back a record, and in
    // which the receiver refuses a result beat.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    int records_sent = 0;
    int quiet_cycles = 0;

    // Range of start values that the current register setting covers; the
    // relation generator spreads its records over it.
    logic [STAMP_BITS-1:0] span_low;
    logic [STAMP_BITS-1:0] span_high;

    equal_width_bucket_boundary_finder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ewbbf_boundary_monitor boundary_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .boundaries_due (boundaries_due),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // The receiver decides afresh on every edge whether it takes a beat.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: a run in which no beat moves on either channel for too long
    // has hung, whatever is still due.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // A register write holds the enable for one edge, then drops it and waits
    // for the next edge, so back-to-back writes never assign it twice in a step.
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one record and returns on the edge that accepts it. Valid stays
    // high into the next call when the sender does not idle.
    task automatic send_record(input logic [STAMP_BITS-1:0] start, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= start;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        records_sent++;
    endtask

    // Drops valid and waits until every due boundary has come out, and then
    // long enough for a record that closes nothing to finish as well. The
    // first edge lets the monitor count the record accepted just before.
    task automatic wait_until_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (boundaries_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_upto(input longint unsigned limit);
        return $urandom_range(0, (limit > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : limit[31:0]);
    endfunction

    // Picks a register setting from a mix of extremes and ordinary ranges and
    // writes all three registers.
    task automatic write_random_setting();
        logic [STAMP_BITS-1:0] lo;
        logic [STAMP_BITS-1:0] hi;
        logic [STAMP_BITS-1:0] swap;
        logic [CUR_BITS-1:0]   nb;
        longint unsigned       wide_hi;
        case ($urandom_range(0, 5))
            0:
            begin
                lo = '0;
                hi = '1;
            end
            1:
            begin
                lo = $urandom;
                wide_hi = longint'(lo) + $urandom_range(1, 5000);
                hi = (wide_hi > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide_hi[31:0];
            end
            2:
            begin
                lo = $urandom;
                hi = lo;
            end
            3:
            begin
                // Max below min: the block falls back to a width of one.
                lo = $urandom | 32'h1;
                hi = $urandom_range(0, lo - 1);
            end
            4:
            begin
                lo = $urandom;
                hi = $urandom;
                if (hi < lo)
                begin
                    swap = lo;
                    lo = hi;
                    hi = swap;
                end
            end
            default:
            begin
                lo = $urandom_range(0, 100);
                hi = lo + $urandom_range(1, 300);
            end
        endcase
        case ($urandom_range(0, 4))
            0:       nb = 1;
            1:       nb = MAX_BUCKETS;
            2:       nb = $urandom_range(0, 127);
            default: nb = $urandom_range(1, 16);
        endcase
        write_register(CFG_MIN_START, lo);
        write_register(CFG_MAX_START, hi);
        write_register(CFG_NUM_BUCKETS, CFG_DATA_BITS'(nb));
        span_low = (hi < lo) ? hi : lo;
        span_high = (hi < lo) ? lo : hi;
    endtask

    // One relation: ascending starts spread a little beyond the configured
    // range, with the odd random start mixed in so that records fall below
    // min, go backward across buckets and exercise every stamp bit.
    task automatic send_relation();
        int              len;
        longint unsigned a;
        longint unsigned b;
        longint unsigned step_max;
        longint unsigned v;
        logic [STAMP_BITS-1:0] start;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
        a = (span_low > 64) ? span_low - $urandom_range(0, 64) : 0;
        b = longint'(span_high) + $urandom_range(0, 64);
        if (b > 32'hFFFF_FFFF)
            b = 32'hFFFF_FFFF;
        step_max = (b - a) / len;
        v = a + random_upto(step_max);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 12)
                start = $urandom;
            else
                start = v[31:0];
            send_record(start, i == len - 1);
            v = v + random_upto(2 * step_max);
            if (v > b)
                v = b;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset values first: one bucket, min and max both
        // zero, so every record lands in bucket zero and only the last
        // record closes it with the record count.
        send_record(32'd0, 1'b0);
        send_record(32'd5, 1'b1);
        wait_until_quiet();

        // A bucket count of zero counts as one. Min equal to max widens the
        // span to one, and a start below min goes to bucket zero.
        write_register(CFG_NUM_BUCKETS, 32'd0);
        write_register(CFG_MIN_START, 32'd10);
        write_register(CFG_MAX_START, 32'd10);
        send_record(32'd3, 1'b0);
        send_record(32'd10, 1'b0);
        send_record(32'd11, 1'b1);
        wait_until_quiet();

        // Full stamp range with a bucket count above the maximum, which is
        // clamped to 64 buckets. The jump to mid-range closes half of them,
        // the step back lands in a lower bucket and closes nothing, and the
        // top value runs the last record through every remaining bucket.
        write_register(CFG_NUM_BUCKETS, 32'd127);
        write_register(CFG_MIN_START, 32'h0000_0000);
        write_register(CFG_MAX_START, 32'hFFFF_FFFF);
        send_record(32'h0000_0000, 1'b0);
        send_record(32'h8000_0000, 1'b0);
        send_record(32'h7000_0000, 1'b0);
        send_record(32'hFFFF_FFFF, 1'b1);
        wait_until_quiet();

        // A lone record that is also the last one closes all 64 buckets.
        send_record(32'hFFFF_FFFF, 1'b1);
        wait_until_quiet();

        // Max below min: the span is zero and the width is forced to one.
        write_register(CFG_MIN_START, 32'd1000);
        write_register(CFG_MAX_START, 32'd200);
        write_register(CFG_NUM_BUCKETS, 32'd4);
        send_record(32'd999, 1'b0);
        send_record(32'd1001, 1'b0);
        send_record(32'd5000, 1'b1);
        wait_until_quiet();

        // Registers changed in the middle of a relation: the width stays at
        // eight from the first record, while the new min and the smaller
        // bucket count take effect at once. The last record then finds
        // every bucket below the new count already closed and emits nothing.
        write_register(CFG_MIN_START, 32'd0);
        write_register(CFG_MAX_START, 32'd64);
        write_register(CFG_NUM_BUCKETS, 32'd8);
        send_record(32'd0, 1'b0);
        send_record(32'd20, 1'b0);
        wait_until_quiet();
        write_register(CFG_NUM_BUCKETS, 32'd2);
        write_register(CFG_MIN_START, 32'd16);
        send_record(32'd40, 1'b0);
        send_record(32'd41, 1'b1);
        // The next relation recomputes its width from the new registers.
        send_record(32'd7, 1'b1);
        wait_until_quiet();

        // Random part: four handshake modes, each run through three register
        // settings. Registers are only rewritten once the block is quiet.
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 61;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 61;
                end
                default:
                begin
                    sender_idle_pct = 7;
                    receiver_stall_pct = 7;
                end
            endcase
            for (int setting = 0; setting < 3; setting++)
            begin
                int target;
                wait_until_quiet();
                write_random_setting();
                target = records_sent + RECORDS_PER_SETTING;
                while (records_sent < target)
                    send_relation();
            end
        end

        wait_until_quiet();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
